### hw/rtl/kts_pkg.sv
// Shared types, constants and a helper function for the keyframe track sampler.
`default_nettype none
package kts_pkg;

  localparam int unsigned MaxKeysDefault = 256;
  localparam int unsigned CountW = 9;
  localparam int unsigned FracBits = 16;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  key_index;
    logic [31:0] time_value;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [31:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic [31:0] sample_time;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [1:0]  flags;
  } out_word_t;

  // One table entry as held in the key RAM.
  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } key_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  // Clamp a signed 64-bit value to the signed 32-bit range.
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/kts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/kts_divider.sv
// Serial restoring signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module kts_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [48:0] num_i,
  input  wire logic signed [32:0] den_i,
  output logic                    done_o,
  output logic signed [49:0]      quot_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [48:0] dvd_q, dvd_d;
  logic [32:0] dvs_q, dvs_d;
  logic [32:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [33:0] sh;
  logic        fits;

  assign sh   = {rem_q, dvd_q[48]};
  assign fits = sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      dvd_d  = num_i[48] ? (~num_i + 49'd1) : num_i;
      dvs_d  = den_i[32] ? (~den_i + 33'd1) : den_i;
      rem_d  = 33'd0;
      neg_d  = num_i[48] ^ den_i[32];
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when the divisor fits
      rem_d = fits ? 33'(sh - {1'b0, dvs_q}) : sh[32:0];
      dvd_d = {dvd_q[47:0], fits};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd48) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule
`default_nettype wire

### hw/rtl/keyframe_track_sampler.sv
// Top level of the keyframe track sampler: key table, search and interpolation sequencer.
`default_nettype none
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries one word per item.
//   A write word (op = write) stores a key at key_index and gives no
//   result; slots at or beyond MAX_KEYS are dropped. A sample word binary-searches
//   the table and returns one output word on out_valid_o / out_stall_i / out_word_o.
//   A sample runs the search steps (RAM read, compare) until the range closes,
//   then the key reads, a check of the segment length, the serial divider (one
//   quotient bit a cycle), a multiply and an add per axis on the shared
//   multiplier and the load of the output register; the last key or a
//   zero-length segment skips the divider. The divider and the single RAM read
//   port set how long a sample takes, and the block
//   takes one item at a time: in_stall_o is high from acceptance of a sample
//   until its result is loaded into the output register.
//   A finished result waits in the output register while out_stall_i is high;
//   the block holds in its final state until the register frees.
//   cfg_we_i writes key_count (cfg_data_i); write it only while idle.
//   Reset: key_count returns to 1, the sequencer idles, the output register
//   empties. Table contents are undefined until written.
module keyframe_track_sampler #(
  parameter int unsigned MAX_KEYS = kts_pkg::MaxKeysDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire kts_pkg::in_word_t          in_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output kts_pkg::out_word_t              out_word_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [kts_pkg::CountW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MAX_KEYS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SRCH  = 10'b00_0000_0010,
    S_SCMP  = 10'b00_0000_0100,
    S_LEFT  = 10'b00_0000_1000,
    S_RIGHT = 10'b00_0001_0000,
    S_DIV   = 10'b00_0010_0000,
    S_MUL   = 10'b00_0100_0000,
    S_ADD   = 10'b00_1000_0000,
    S_DONE  = 10'b01_0000_0000,
    S_START = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [kts_pkg::CountW-1:0] key_count_q;

  // sample context
  logic [31:0]     t_q, t_d;
  logic [IdxW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, last_q, last_d;
  logic [IdxW:0]   mid_w;
  kts_pkg::key_t   left_q, left_d, right_q, right_d;
  logic signed [31:0] f_q, f_d;
  logic signed [64:0] prod_q, prod_d;
  logic [1:0]      lane_q, lane_d;
  logic [31:0]     rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic            sat_q, sat_d, zero_q, zero_d;

  // output register
  logic               out_valid_q, out_valid_d;
  kts_pkg::out_word_t out_q, out_d;

  // RAM
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  kts_pkg::key_t   ram_wdata, ram_rdata;

  // divider
  logic               div_start, div_done;
  logic signed [48:0] div_num;
  logic signed [32:0] div_den;
  logic signed [49:0] div_quot;

  logic signed [32:0] tdiff, den, dv;
  logic [31:0]        v0, n_eff;
  logic signed [64:0] sum;
  kts_pkg::sat_t      fsat, vsat;
  logic               in_acc;

  assign in_acc = in_valid_i && (state_q == S_IDLE);

  assign ram_we    = in_acc && (in_word_i.op == kts_pkg::OP_WRITE)
                     && (32'(in_word_i.key_index) < MAX_KEYS);
  assign ram_waddr = IdxW'(32'(in_word_i.key_index));
  assign ram_wdata = '{t: in_word_i.time_value, x: in_word_i.in_x,
                       y: in_word_i.in_y, z: in_word_i.in_z};

  kts_ram #(
    .Width ($bits(kts_pkg::key_t)),
    .Depth (MAX_KEYS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign tdiff   = $signed({t_q[31], t_q}) - $signed({left_q.t[31], left_q.t});
  assign den     = $signed({right_q.t[31], right_q.t}) - $signed({left_q.t[31], left_q.t});
  assign div_num = {tdiff, 16'd0};
  assign div_den = den;

  kts_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign mid_w = ({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1;
  assign fsat  = kts_pkg::sat32(64'(div_quot));

  always_comb begin
    n_eff = 32'(key_count_q);
    if (n_eff == 32'd0) begin
      n_eff = 32'd1;
    end else if (n_eff > MAX_KEYS) begin
      n_eff = MAX_KEYS;
    end
  end

  // lane selection for the shared multiplier
  always_comb begin
    case (lane_q)
      2'd0: begin
        v0 = left_q.x;
        dv = $signed({right_q.x[31], right_q.x}) - $signed({left_q.x[31], left_q.x});
      end
      2'd1: begin
        v0 = left_q.y;
        dv = $signed({right_q.y[31], right_q.y}) - $signed({left_q.y[31], left_q.y});
      end
      default: begin
        v0 = left_q.z;
        dv = $signed({right_q.z[31], right_q.z}) - $signed({left_q.z[31], left_q.z});
      end
    endcase
  end

  assign sum  = 65'($signed(v0)) + (prod_q >>> kts_pkg::FracBits);
  assign vsat = kts_pkg::sat32(sum[63:0]);

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    last_d      = last_q;
    left_d      = left_q;
    right_d     = right_q;
    f_d         = f_q;
    prod_d      = prod_q;
    lane_d      = lane_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    rz_d        = rz_q;
    sat_d       = sat_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_raddr   = lo_q;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_word_i.op == kts_pkg::OP_SAMPLE)) begin
          t_d     = in_word_i.time_value;
          lo_d    = '0;
          hi_d    = IdxW'(n_eff - 32'd1);
          last_d  = IdxW'(n_eff - 32'd1);
          sat_d   = 1'b0;
          zero_d  = 1'b0;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          ram_raddr = mid_w[IdxW-1:0];
          mid_d     = mid_w[IdxW-1:0];
          state_d   = S_SCMP;
        end else begin
          ram_raddr = lo_q;
          state_d   = S_LEFT;
        end
      end
      S_SCMP: begin
        if ($signed(t_q) < $signed(ram_rdata.t)) begin
          hi_d = mid_q - 1'b1;
        end else begin
          lo_d = mid_q;
        end
        state_d = S_SRCH;
      end
      S_LEFT: begin
        left_d = ram_rdata;
        rx_d   = ram_rdata.x;
        ry_d   = ram_rdata.y;
        rz_d   = ram_rdata.z;
        if (lo_q == last_q) begin
          state_d = S_DONE;
        end else begin
          ram_raddr = lo_q + 1'b1;
          state_d   = S_RIGHT;
        end
      end
      S_RIGHT: begin
        right_d = ram_rdata;
        state_d = S_START;
      end
      S_START: begin
        // zero-length segment: hold the left key
        if (den == 33'sd0) begin
          zero_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          f_d     = $signed(fsat.val);
          sat_d   = fsat.sat;
          lane_d  = 2'd0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = f_q * dv;
        state_d = S_ADD;
      end
      S_ADD: begin
        sat_d = sat_q | vsat.sat;
        case (lane_q)
          2'd0:    rx_d = vsat.val;
          2'd1:    ry_d = vsat.val;
          default: rz_d = vsat.val;
        endcase
        if (lane_q == 2'd2) begin
          state_d = S_DONE;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.sample_time = t_q;
          out_d.out_x       = rx_q;
          out_d.out_y       = ry_q;
          out_d.out_z       = rz_q;
          out_d.flags       = {zero_q, sat_q};
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_count_q <= kts_pkg::CountW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    last_q  <= last_d;
    left_q  <= left_d;
    right_q <= right_d;
    f_q     <= f_d;
    prod_q  <= prod_d;
    lane_q  <= lane_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    rz_q    <= rz_d;
    sat_q   <= sat_d;
    zero_q  <= zero_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire
